// File: sv/smas_pkg.sv
// shared types, constants and arithmetic helpers for the stereo mixing buffer
package smas_pkg;

    localparam int SLOT_W   = 9;
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 8;
    localparam int VOL_W    = 10;
    localparam int SUM_W    = 32;
    localparam int TERM_W   = 16;
    localparam int PROD_W   = SUM_W + VOL_W + 1;
    localparam int SHIFT    = 8;

    localparam logic [VOL_W-1:0]    VOL_RESET = 10'd256;
    localparam logic [SAMPLE_W-1:0] SAT_MAX   = 16'h7fff;
    localparam logic [SAMPLE_W-1:0] SAT_MIN   = 16'h8000;

    localparam logic KIND_ACC  = 1'b0;
    localparam logic KIND_XFER = 1'b1;

    localparam logic REG_MASTER_VOLUME = 1'b0;

    typedef struct packed {
        logic                       kind;
        logic [SLOT_W-1:0]          slot;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       byte_mode;
        logic [GAIN_W-1:0]          left_gain;
        logic [GAIN_W-1:0]          right_gain;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0]          out_slot;
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic calc;
        logic exec;
        logic load_out;
        logic clear_step;
    } t_cmd;

    typedef struct packed {
        logic is_xfer;
        logic out_busy;
        logic clr_last;
    } t_sts;

    function automatic logic signed [TERM_W-1:0] voice_term(
        input logic signed [SAMPLE_W-1:0] sample,
        input logic                       byte_mode,
        input logic [GAIN_W-1:0]          gain
    );
        logic signed [13:0] bp;
        logic signed [24:0] wp;
        bp = 14'($signed(sample[7:0])) * 14'($signed({1'b0, gain[7:3]}));
        wp = 25'(sample) * 25'($signed({1'b0, gain}));
        if (byte_mode) begin
            return $signed({bp[12:0], 3'b000});
        end else begin
            return wp[23:8];
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] saturate(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1-(SAMPLE_W+SHIFT-1):0] hi;
        hi = p[PROD_W-1:SAMPLE_W+SHIFT-1];
        if (hi == '0 || hi == '1) begin
            return p[SAMPLE_W+SHIFT-1:SHIFT];
        end else if (p[PROD_W-1]) begin
            return SAT_MIN;
        end else begin
            return SAT_MAX;
        end
    endfunction

endpackage

// File: sv/smas_stream_if.sv
// valid/ready stream channel carrying one payload item per transfer
interface smas_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/smas_ram.sv
// generic single write port ram with registered read
module smas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/smas_ctrl.sv
// controller state machine sequencing clear, read, update and output load
module smas_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  smas_pkg::t_sts i_sts,
    output smas_pkg::t_cmd o_cmd
);
    import smas_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC,
        S_SAT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_sts.clr_last) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_READ;
            S_READ:  n_state = S_EXEC;
            S_EXEC:  n_state = i_sts.is_xfer ? S_SAT : S_IDLE;
            S_SAT:   if (!i_sts.out_busy) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_cmd.capture      = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.calc         = (r_state == S_READ);
    assign o_cmd.exec         = (r_state == S_EXEC);
    assign o_cmd.load_out     = (r_state == S_SAT) && !i_sts.out_busy;
    assign o_cmd.clear_step   = (r_state == S_CLEAR);
endmodule

// File: sv/smas_datapath.sv
// datapath: slot sums memory, voice scaling, master multiply, saturation, output register
module smas_datapath #(
    parameter int SLOTS = 512
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  smas_pkg::t_cmd                         i_cmd,
    output smas_pkg::t_sts                         o_sts,
    input  smas_pkg::t_in_item                     i_in_item,
    input  logic [smas_pkg::VOL_W-1:0]             i_master_volume,
    output smas_pkg::t_out_item                    o_out_item,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready
);
    import smas_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int EW = (AW > SLOT_W) ? AW : SLOT_W;

    t_in_item                  r_item;
    logic                      r_in_range;
    logic [AW-1:0]             r_addr;
    logic signed [TERM_W-1:0]  r_lterm;
    logic signed [TERM_W-1:0]  r_rterm;
    logic signed [PROD_W-1:0]  r_lprod;
    logic signed [PROD_W-1:0]  r_rprod;
    t_out_item                 r_out_item;
    logic                      r_out_valid;
    logic [AW-1:0]             r_clr_idx;

    logic [EW-1:0]             slot_ext;
    logic [SUM_W-1:0]          l_rdata;
    logic [SUM_W-1:0]          r_rdata_w;
    logic signed [SUM_W-1:0]   l_sum;
    logic signed [SUM_W-1:0]   r_sum;
    logic                      we;
    logic [AW-1:0]             waddr;
    logic [SUM_W-1:0]          l_wdata;
    logic [SUM_W-1:0]          r_wdata;

    assign slot_ext = EW'(i_in_item.slot);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item     <= i_in_item;
            r_addr     <= slot_ext[AW-1:0];
            r_in_range <= (32'(i_in_item.slot) < 32'(SLOTS));
        end
        if (i_cmd.calc) begin
            r_lterm <= voice_term(r_item.sample, r_item.byte_mode, r_item.left_gain);
            r_rterm <= voice_term(r_item.sample, r_item.byte_mode, r_item.right_gain);
        end
        if (i_cmd.exec) begin
            r_lprod <= PROD_W'(l_sum) * PROD_W'($signed({1'b0, i_master_volume}));
            r_rprod <= PROD_W'(r_sum) * PROD_W'($signed({1'b0, i_master_volume}));
        end
        if (i_cmd.load_out) begin
            r_out_item.out_slot  <= r_item.slot;
            r_out_item.left_out  <= saturate(r_lprod);
            r_out_item.right_out <= saturate(r_rprod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_clr_idx   <= '0;
        end else begin
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clear_step) begin
                r_clr_idx <= r_clr_idx + AW'(1);
            end
        end
    end

    // out of range slots read as zero
    assign l_sum = r_in_range ? $signed(l_rdata) : '0;
    assign r_sum = r_in_range ? $signed(r_rdata_w) : '0;

    assign we    = i_cmd.clear_step || (i_cmd.exec && r_in_range);
    assign waddr = i_cmd.clear_step ? r_clr_idx : r_addr;

    always_comb begin
        if (i_cmd.clear_step || r_item.kind == KIND_XFER) begin
            l_wdata = '0;
            r_wdata = '0;
        end else begin
            l_wdata = l_rdata + SUM_W'(r_lterm);
            r_wdata = r_rdata_w + SUM_W'(r_rterm);
        end
    end

    smas_ram #(
        .WIDTH (SUM_W),
        .DEPTH (SLOTS)
    ) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (l_wdata),
        .i_re    (i_cmd.calc),
        .i_raddr (r_addr),
        .o_rdata (l_rdata)
    );

    smas_ram #(
        .WIDTH (SUM_W),
        .DEPTH (SLOTS)
    ) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (r_wdata),
        .i_re    (i_cmd.calc),
        .i_raddr (r_addr),
        .o_rdata (r_rdata_w)
    );

    assign o_sts.is_xfer  = (r_item.kind == KIND_XFER);
    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_sts.clr_last = (r_clr_idx == AW'(SLOTS - 1));

    assign o_out_item  = r_out_item;
    assign o_out_valid = r_out_valid;
endmodule

// File: sv/stereo_mix_accumulate_saturate.sv
// top level of the stereo mixing buffer with saturating transfer
//
// input channel i_in carries one item per transfer: kind 0 adds a scaled voice
// sample into a slot's left and right sums, kind 1 reads the slot, applies the
// master volume, saturates to 16 bits, sends one result on o_out and clears it
// the apb port holds master_volume at byte address 0 (reset value 256)
// each item passes through the read-modify-write of the sums memory, and a new
// item is accepted only once the last is through: read and scale, write back
// with the master multiply, then for a transfer saturate into the output register
// a transfer result is valid on o_out once the saturate step loads the output register
// after reset the sums memory is swept to zero, one slot per cycle, so i_in
// stays not ready until every slot is cleared; apb writes are taken meanwhile
// while o_out stalls, the output register holds its result and the block still
// accepts accumulates; a following transfer waits in its last step until the
// output register is free
module stereo_mix_accumulate_saturate #(
    parameter int SLOTS = 512
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    smas_stream_if.sink         i_in,
    smas_stream_if.source       o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import smas_pkg::*;

    logic [VOL_W-1:0] r_master_volume;
    t_cmd             cmd;
    t_sts             sts;
    logic             in_ready;
    t_out_item        out_item;
    logic             out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_volume <= VOL_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_MASTER_VOLUME) begin
            r_master_volume <= pwdata[VOL_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_MASTER_VOLUME) ? 32'(r_master_volume) : '0;
    assign pready = 1'b1;

    smas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    smas_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_in_item       (i_in.data),
        .i_master_volume (r_master_volume),
        .o_out_item      (out_item),
        .o_out_valid     (out_valid),
        .i_out_ready     (o_out.ready)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.data  = out_item;
endmodule
